>>> design/vrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vrq_pkg;

  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 32;
  localparam int PROD_W   = 64;
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 16;
  localparam int CNT_W    = 2;

  localparam logic [MODE_W-1:0] MODE_1BIT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_2BIT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_4BIT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_8BIT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_16BIT = 3'd4;

  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_GAIN = 1'b1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 32'h0001_0000;

  localparam logic [CNT_W-1:0] CNT_BYTE = 2'd1;
  localparam logic [CNT_W-1:0] CNT_WORD = 2'd2;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              neg_in;
  } prod_stage_t;

  // log2 of the code width; undefined modes behave as 16 bit
  function automatic logic [2:0] mode_log2(input logic [MODE_W-1:0] mode);
    logic [2:0] res;
    case (mode)
      MODE_1BIT: res = 3'd0;
      MODE_2BIT: res = 3'd1;
      MODE_4BIT: res = 3'd2;
      MODE_8BIT: res = 3'd3;
      default:   res = 3'd4;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/vrq_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface vrq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface vrq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] packed_data;
  logic [1:0]  byte_count;

  modport source (output valid, output packed_data, output byte_count, input ready);
  modport sink   (input valid, input packed_data, input byte_count, output ready);
endinterface
`default_nettype wire

>>> design/voltage_requantize_pack.sv
// latency: an accepted item passes the sample register, the product register and the output register in turn
// throughput: one item per cycle while the receiver is ready; the 32x32 gain multiply has a stage to itself
// in 1, 2 and 4 bit modes a result follows every 8, 4 or 2 items
// reset (rst_n low, synchronous): pipeline emptied, partial byte cleared,
// mode 8 bit and gain 1.0
`timescale 1ns / 1ps
`default_nettype none
module voltage_requantize_pack
  import vrq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  vrq_in_if.sink           in_ch,
  vrq_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  logic [MODE_W-1:0] mode_r;
  logic [GAIN_W-1:0] gain_r;
  logic              mode_clear;
  logic              mid_valid;
  logic              mid_ready;
  prod_stage_t       mid_data;

  assign mode_clear = cfg_we && (cfg_index == CFG_IDX_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_8BIT;
      gain_r <= GAIN_ONE;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_MODE) begin
        mode_r <= cfg_wdata[MODE_W-1:0];
      end else begin
        gain_r <= cfg_wdata[GAIN_W-1:0];
      end
    end
  end

  vrq_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.sample),
    .gain      (gain_r),
    .dn_valid  (mid_valid),
    .dn_ready  (mid_ready),
    .dn_data   (mid_data)
  );

  vrq_pack u_pack (
    .clk             (clk),
    .rst_n           (rst_n),
    .mode            (mode_r),
    .mode_clear      (mode_clear),
    .up_valid        (mid_valid),
    .up_ready        (mid_ready),
    .up_data         (mid_data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_packed_data (out_ch.packed_data),
    .out_byte_count  (out_ch.byte_count)
  );

endmodule
`default_nettype wire

>>> design/vrq_mult.sv
`timescale 1ns / 1ps
`default_nettype none
module vrq_mult
  import vrq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [GAIN_W-1:0]   gain,
  output logic                     dn_valid,
  input  wire logic                dn_ready,
  output prod_stage_t              dn_data
);

  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  logic                s2_valid_r;
  prod_stage_t         s2_r;
  prod_stage_t         s2_nxt;
  logic                s1_ready;
  logic                s2_take;
  logic [SAMPLE_W-1:0] abs_in;

  assign s2_take  = !s2_valid_r || dn_ready;
  assign s1_ready = !s1_valid_r || s2_take;
  assign in_ready = s1_ready;

  // magnitude of the sample; the most negative value maps to 2^31
  always_comb begin
    abs_in = s1_sample_r[SAMPLE_W-1] ? (~s1_sample_r + 1'b1) : s1_sample_r;
    s2_nxt.neg_in = s1_sample_r[SAMPLE_W-1];
    s2_nxt.prod   = PROD_W'(abs_in) * PROD_W'(gain);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_take) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_sample_r <= in_sample;
    end
    if (s1_valid_r && s2_take) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_r;

endmodule
`default_nettype wire

>>> design/vrq_pack.sv
`timescale 1ns / 1ps
`default_nettype none
module vrq_pack
  import vrq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic              mode_clear,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire prod_stage_t       up_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_packed_data,
  output logic [CNT_W-1:0]       out_byte_count
);

  logic              out_valid_r;
  logic [DATA_W-1:0] data_r;
  logic [CNT_W-1:0]  count_r;
  logic [7:0]        partial_r;
  logic [2:0]        slot_r;

  logic              out_take;
  logic [2:0]        sh;
  logic              neg;
  logic [31:0]       r;
  logic [31:0]       lim;
  logic [31:0]       mag;
  logic [DATA_W-1:0] code;
  logic              packing;
  logic [2:0]        slot_last;
  logic [2:0]        slot;
  logic [2:0]        shamt;
  logic [7:0]        mask8;
  logic [7:0]        part_new;
  logic              emit;
  logic [DATA_W-1:0] data_nxt;
  logic [CNT_W-1:0]  count_nxt;

  assign out_take = !out_valid_r || out_ready;
  assign up_ready = out_take;

  // round half away from zero after the -0.5 offset, then saturate; 1 bit mode keeps only the sample sign
  always_comb begin
    sh = mode_log2(mode);
    if (up_data.neg_in) begin
      neg = 1'b1;
      r   = up_data.prod[63:32] + 32'd1;
    end else if (|up_data.prod[63:31]) begin
      neg = 1'b0;
      r   = up_data.prod[63:32];
    end else begin
      neg = 1'b1;
      r   = (up_data.prod == '0) ? 32'd1 : 32'd0;
    end
    lim = 32'd1 << ((5'd1 << sh) - 5'd1);
    if (neg) begin
      mag  = (r > lim) ? lim : r;
      code = DATA_W'(32'd0 - mag);
    end else begin
      mag  = (r > (lim - 32'd1)) ? (lim - 32'd1) : r;
      code = DATA_W'(mag);
    end
    if (sh == 3'd0) begin
      code = {{(DATA_W-1){1'b0}}, !up_data.neg_in};
    end
  end

  // sub-byte packing, lowest slot first; 8 and 16 bit codes go out whole
  always_comb begin
    packing   = (sh < 3'd3);
    slot_last = 3'(3'd7 >> sh);
    slot      = (slot_r > slot_last) ? 3'd0 : slot_r;
    shamt     = 3'(slot << sh);
    mask8     = 8'((9'd1 << (4'd1 << sh)) - 9'd1);
    part_new  = ((slot == 3'd0) ? 8'd0 : partial_r) | ((code[7:0] & mask8) << shamt);
    emit      = !packing || (slot == slot_last);
    if (packing) begin
      data_nxt  = {8'd0, part_new};
      count_nxt = CNT_BYTE;
    end else if (sh == 3'd3) begin
      data_nxt  = {8'd0, code[7:0]};
      count_nxt = CNT_BYTE;
    end else begin
      data_nxt  = code;
      count_nxt = CNT_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      partial_r   <= 8'd0;
      slot_r      <= 3'd0;
    end else begin
      if (out_take) begin
        out_valid_r <= up_valid && emit;
      end
      if (mode_clear) begin
        partial_r <= 8'd0;
        slot_r    <= 3'd0;
      end else if (up_valid && out_take && packing) begin
        if (slot == slot_last) begin
          partial_r <= 8'd0;
          slot_r    <= 3'd0;
        end else begin
          partial_r <= part_new;
          slot_r    <= slot + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && out_take && emit) begin
      data_r  <= data_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_data = data_r;
  assign out_byte_count  = count_r;

endmodule
`default_nettype wire

>>> design/vrq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module vrq_props
  import vrq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_packed_data,
  input wire logic [CNT_W-1:0]  out_byte_count
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item present after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count == CNT_BYTE || out_byte_count == CNT_WORD))
    else $error("byte count out of range");

  // single byte items keep the upper byte clear
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_byte_count == CNT_BYTE) |-> (out_packed_data[15:8] == 8'd0))
    else $error("upper byte set on a one byte item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_packed_data) && $stable(out_byte_count)))
    else $error("stalled item changed");

endmodule

bind voltage_requantize_pack vrq_props u_vrq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_packed_data (out_ch.packed_data),
  .out_byte_count  (out_ch.byte_count)
);
`default_nettype wire

>>> tb/vrq_checker.sv
`timescale 1ns / 1ps
module vrq_checker
  import vrq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  vrq_in_if                    in_ch,
  vrq_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_wdata,
  output int                   mismatches,
  output int                   outstanding,
  output int                   words_checked
);

  localparam logic [PROD_W-1:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  cnt;
  } packed_word_t;

  packed_word_t      expected_words[$];
  logic [MODE_W-1:0] mode_r;
  logic [GAIN_W-1:0] gain_r;
  logic [7:0]        partial_byte;
  logic [2:0]        slot_idx;
  int                err_cnt = 0;
  int                ok_cnt  = 0;

  function automatic int unsigned code_bits(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_1BIT: return 1;
      MODE_2BIT: return 2;
      MODE_4BIT: return 4;
      MODE_8BIT: return 8;
      default:   return 16;
    endcase
  endfunction

  // scale by gain, take off one half, round away from zero, saturate to nbits
  function automatic logic [15:0] scale_and_round(input logic [SAMPLE_W-1:0] raw,
                                                  input logic [GAIN_W-1:0] g,
                                                  input int unsigned nbits);
    logic [PROD_W-1:0] mag_in, prod, mag, rnd, lim;
    logic              neg;
    mag_in = {32'd0, (raw[31] ? (~raw + 32'd1) : raw)};
    prod   = mag_in * {32'd0, g};
    if (raw[31]) begin
      neg = 1'b1;
      mag = prod + HALF_Q32;
    end else if (prod >= HALF_Q32) begin
      neg = 1'b0;
      mag = prod - HALF_Q32;
    end else begin
      neg = 1'b1;
      mag = HALF_Q32 - prod;
    end
    rnd = (mag + HALF_Q32) >> 32;
    lim = 64'd1 << (nbits - 1);
    if (neg) begin
      if (rnd > lim) rnd = lim;
      rnd = 64'd0 - rnd;
    end else if (rnd > lim - 64'd1) begin
      rnd = lim - 64'd1;
    end
    return rnd[15:0];
  endfunction

  task automatic pack_sample(input logic [SAMPLE_W-1:0] raw);
    int unsigned nbits, slots, s;
    logic [15:0] code, mask;
    nbits = code_bits(mode_r);
    if (nbits == 1) code = raw[31] ? 16'd0 : 16'd1;
    else code = scale_and_round(raw, gain_r, nbits);
    if (nbits == 16) begin
      expected_words.push_back('{code, CNT_WORD});
    end else if (nbits == 8) begin
      expected_words.push_back('{{8'h00, code[7:0]}, CNT_BYTE});
    end else begin
      slots = 8 / nbits;
      mask  = (16'd1 << nbits) - 16'd1;
      s     = slot_idx;
      if (s >= slots) s = 0;
      if (s == 0) partial_byte = 8'h00;
      partial_byte = partial_byte | 8'((code & mask) << (s * nbits));
      if (s == slots - 1) begin
        expected_words.push_back('{{8'h00, partial_byte}, CNT_BYTE});
        partial_byte = 8'h00;
        slot_idx     = 3'd0;
      end else begin
        slot_idx = 3'(s + 1);
      end
    end
  endtask

  always @(posedge clk) begin
    packed_word_t got, want;
    if (!rst_n) begin
      mode_r       = MODE_8BIT;
      gain_r       = GAIN_ONE;
      partial_byte = 8'h00;
      slot_idx     = 3'd0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_MODE) begin
          mode_r       = cfg_wdata[MODE_W-1:0];
          partial_byte = 8'h00;
          slot_idx     = 3'd0;
        end else begin
          gain_r = cfg_wdata;
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.packed_data, out_ch.byte_count};
        if (expected_words.size() == 0) begin
          $error("unexpected result item: packed_data %h byte_count %0d", got.data, got.cnt);
          err_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (got.data !== want.data) begin
            $error("packed_data: expected %h, got %h", want.data, got.data);
            err_cnt++;
          end
          if (got.cnt !== want.cnt) begin
            $error("byte_count: expected %0d, got %0d", want.cnt, got.cnt);
            err_cnt++;
          end
          ok_cnt++;
        end
      end
      if (in_ch.valid && in_ch.ready) pack_sample(in_ch.sample);
    end
    mismatches    <= err_cnt;
    outstanding   <= expected_words.size();
    words_checked <= ok_cnt;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import vrq_pkg::*;

  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASES          = 20;
  localparam int ITEMS_PER_PHASE = 35;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  int          mismatches;
  int          outstanding;
  int          words_checked;
  int          src_idle = 0;
  int          snk_idle = 0;
  bit          hold_req = 1'b0;
  int          cycle_cnt = 0;
  int          samples_sent = 0;
  int          configs_done = 0;

  vrq_in_if  in_ch ();
  vrq_out_if out_ch ();

  voltage_requantize_pack i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  vrq_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("voltage_requantize_pack verification failed");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
        @(posedge clk);
      end
    end
  end

  task automatic send_sample(input logic [31:0] s);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  task automatic send_all(input logic [31:0] vals[$]);
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  // let the block drain, then it is safe to touch the registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [31:0] g);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_wdata <= {29'd0, mode};
    @(posedge clk);
    cfg_index <= CFG_IDX_GAIN;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    configs_done++;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2:       return GAIN_ONE;
      3:       return $urandom;
      4:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom_range(32'h100, 32'h2000);
    endcase
  endfunction

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      2: begin
        // exactly on a half
        v = ($urandom_range(0, 31) << 16) | 32'h8000;
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7fff_ffff;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'hffff);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0]       dir_q[$];
    logic [MODE_W-1:0] mode;
    logic [31:0]       g;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_IDX_MODE;
    cfg_wdata    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first: 8 bit, unity gain
    dir_q = {32'h0000_8000, 32'h0001_8000, 32'hffff_8000, 32'h7fff_ffff, 32'h8000_0000};
    send_all(dir_q);

    configure(MODE_16BIT, 32'hffff_ffff);
    dir_q = {32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001};
    send_all(dir_q);

    // undefined modes with zero gain
    configure(3'd5, 32'h0000_0000);
    send_sample(32'h1234_5678);
    configure(3'd7, 32'h0000_0000);
    send_sample(32'h8000_0000);

    configure(MODE_1BIT, 32'h0000_0000);
    dir_q = {32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
             32'h7fff_ffff, 32'h0001_0000, 32'hfff0_0000, 32'h0000_0000};
    send_all(dir_q);

    configure(MODE_2BIT, GAIN_ONE);
    dir_q = {32'h0001_8000, 32'h0002_8000, 32'hfffe_0000, 32'hffff_8000};
    send_all(dir_q);

    // last item leaves a half-filled byte that the next mode write drops
    configure(MODE_4BIT, GAIN_ONE);
    dir_q = {32'h0007_8000, 32'hfff7_0000, 32'h0010_0000};
    send_all(dir_q);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 7) begin
        src_idle = 30;
        snk_idle = 47;
      end else if (ph < 14) begin
        src_idle = 47;
        snk_idle = 30;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      case (ph)
        0: begin
          mode = MODE_1BIT;
          g    = 32'hffff_ffff;
        end
        1: begin
          mode = MODE_16BIT;
          g    = 32'h0000_0000;
        end
        2: begin
          mode = MODE_8BIT;
          g    = pick_gain();
        end
        default: begin
          mode = MODE_W'($urandom_range(0, 7));
          g    = pick_gain();
        end
      endcase
      configure(mode, g);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 2 && k == 4) hold_req = 1'b1;
        send_sample(pick_sample());
      end
    end

    settle();
    $display("%0d samples over %0d register settings, %0d result items compared",
             samples_sent, configs_done, words_checked);
    if (mismatches == 0) begin
      $display("voltage_requantize_pack verification clean");
    end else begin
      $display("voltage_requantize_pack verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/vrq_pkg.sv
design/vrq_if.sv
design/vrq_mult.sv
design/vrq_pack.sv
design/voltage_requantize_pack.sv
design/vrq_checker.sv
tb/vrq_checker.sv
tb/tb_top.sv
